// File: hdl/alc_pkg.sv
// Shared types, result codes and coefficient tables for the ambient light lux converter.
// No dependencies; every other file of the block imports this package.
package alc_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int DIV_STEPS       = 32;

    localparam logic [8:0]  SCALE_RESET   = 9'd256;
    localparam logic [14:0] COEF_A        = 15'd27615;
    localparam logic [17:0] LUX_INT_MAX   = 18'h3FFFF;
    localparam logic [19:0] LUX_MICRO_MAX = 20'd999999;
    localparam logic [19:0] MICRO_SCALE   = 20'd1000000;
    localparam logic [36:0] CORR_ONE      = 37'd65536;

    localparam logic [2:0] CODE_OK   = 3'd0;
    localparam logic [2:0] CODE_BUSY = 3'd1;
    localparam logic [2:0] CODE_SAT  = 3'd2;
    localparam logic [2:0] CODE_ZERO = 3'd3;
    localparam logic [2:0] CODE_NEG  = 3'd4;

    localparam logic [1:0] REGION_LOW  = 2'd0;
    localparam logic [1:0] REGION_MID  = 2'd1;
    localparam logic [1:0] REGION_HIGH = 2'd2;
    localparam logic [1:0] REGION_TOP  = 2'd3;

    typedef struct packed {
        logic [7:0]  status_byte;
        logic [15:0] ch0_count;
        logic [15:0] ch1_count;
    } t_sample;

    typedef struct packed {
        logic [2:0]  result_code;
        logic [17:0] lux_integer;
        logic [19:0] lux_micro;
    } t_result;

    typedef struct packed {
        logic [2:0] code;
        logic [1:0] region;
    } t_tag;

    typedef struct packed {
        t_tag        tag;
        logic [15:0] ch0;
        logic [15:0] ch1;
        logic [8:0]  scale;
    } t_item;

    // Linear term is a 41-bit two's complement value.
    typedef struct packed {
        t_tag        tag;
        logic [40:0] lin;
    } t_div_side;

    function automatic logic [12:0] coef_b(input logic [1:0] region);
        logic [12:0] v;
        unique case (region) inside
            REGION_LOW, REGION_MID: v = 13'd424;
            default:                v = 13'd4244;
        endcase
        return v;
    endfunction

    function automatic logic [14:0] coef_off(input logic [1:0] region);
        logic [14:0] v;
        unique case (region) inside
            REGION_LOW, REGION_MID: v = 15'd19005;
            REGION_HIGH:            v = 15'd18677;
            default:                v = 15'd19267;
        endcase
        return v;
    endfunction

    function automatic logic [27:0] coef_k(input logic [1:0] region);
        logic [27:0] v;
        unique case (region)
            REGION_LOW:  v = 28'd0;
            REGION_MID:  v = 28'd97861501;
            REGION_HIGH: v = 28'd167772160;
            default:     v = 28'd23773315;
        endcase
        return v;
    endfunction

    function automatic logic coef_k_neg(input logic [1:0] region);
        return (region == REGION_HIGH) || (region == REGION_TOP);
    endfunction

endpackage

// File: hdl/ambient_light_lux_converter.sv
// Top level of the ambient light lux converter: scale register, front end, middle queue and
// back-end pipeline. Depends on alc_pkg, alc_front, alc_queue and alc_back.
//
//   Channel   Direction  Handshake         Word
//   sample    in         push / full       t_sample: status_byte, ch0_count, ch1_count
//   result    out        pop / empty       t_result: result_code, lux_integer, lux_micro
//   config    in         i_cfg_we          i_cfg_wdata: count_scale, 9 bits
//
// One sample word is taken per cycle and one result word given per cycle, sustained while
// every result is popped at once. On its way a word passes the front register, the queue,
// the 32-stage ratio divider and eleven arithmetic stages.
// Reset is synchronous: it empties every stage and sets count_scale to 256.
// While a result waits unpopped the back end holds; the queue and front register then
// fill up, holding QUEUE_DEPTH + 1 words in all, and full rises.
module ambient_light_lux_converter #(
    parameter int QUEUE_DEPTH = alc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  alc_pkg::t_sample i_sample,
    output logic             empty,
    input  logic             pop,
    output alc_pkg::t_result o_result,
    input  logic             i_cfg_we,
    input  logic [8:0]       i_cfg_wdata
);
    import alc_pkg::*;

    logic  [8:0] r_count_scale;
    logic        w_fr_valid;
    t_item       w_fr_item;
    logic        w_q_ready;
    logic        w_q_valid;
    t_item       w_q_item;
    logic        w_q_pop;
    logic        w_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            r_count_scale <= i_cfg_wdata;
        end
    end

    alc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_sample     (i_sample),
        .i_scale      (r_count_scale),
        .o_item_valid (w_fr_valid),
        .o_item       (w_fr_item),
        .i_item_ready (w_q_ready)
    );

    alc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fr_valid),
        .i_item  (w_fr_item),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    alc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_q_valid),
        .i_item       (w_q_item),
        .o_item_pop   (w_q_pop),
        .o_res_valid  (w_res_valid),
        .o_result     (o_result),
        .i_res_pop    (pop)
    );

    assign empty = !w_res_valid;

endmodule

// File: hdl/alc_front.sv
// Front end: takes a sample word, classifies it (status code and ratio region) and holds it
// for the middle queue. Depends on alc_pkg.
module alc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  alc_pkg::t_sample i_sample,
    input  logic [8:0]     i_scale,
    output logic           o_item_valid,
    output alc_pkg::t_item o_item,
    input  logic           i_item_ready
);
    import alc_pkg::*;

    logic        r_valid;
    t_item       r_item;
    t_item       n_item;
    logic        w_accept;
    logic [22:0] w_lhs;
    logic [22:0] w_r29;
    logic [22:0] w_r35;
    logic [22:0] w_r40;

    assign full         = r_valid && !i_item_ready;
    assign w_accept     = push && !full;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    // The scale cancels out of the region test, so raw counts are compared.
    assign w_lhs = 23'(i_sample.ch1_count) * 23'd100;
    assign w_r29 = 23'(i_sample.ch0_count) * 23'd29;
    assign w_r35 = 23'(i_sample.ch0_count) * 23'd35;
    assign w_r40 = 23'(i_sample.ch0_count) * 23'd40;

    always_comb begin
        n_item.ch0   = i_sample.ch0_count;
        n_item.ch1   = i_sample.ch1_count;
        n_item.scale = (i_scale == 9'd0) ? 9'd1 : i_scale;
        if (!i_sample.status_byte[7]) begin
            n_item.tag.code = CODE_BUSY;
        end else if (i_sample.ch0_count == 16'hFFFF) begin
            n_item.tag.code = CODE_SAT;
        end else if (i_sample.ch0_count == 16'd0) begin
            n_item.tag.code = CODE_ZERO;
        end else begin
            n_item.tag.code = CODE_OK;
        end
        if (w_lhs < w_r29) begin
            n_item.tag.region = REGION_LOW;
        end else if (w_lhs < w_r35) begin
            n_item.tag.region = REGION_MID;
        end else if (w_lhs < w_r40) begin
            n_item.tag.region = REGION_HIGH;
        end else begin
            n_item.tag.region = REGION_TOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_item_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

endmodule

// File: hdl/alc_queue.sv
// Short first-in first-out queue of classified words between front and back end.
// Depends on alc_pkg for the word type.
module alc_queue #(
    parameter int DEPTH = alc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  alc_pkg::t_item i_item,
    output logic           o_ready,
    output logic           o_valid,
    output alc_pkg::t_item o_item,
    input  logic           i_pop
);
    import alc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

// File: hdl/alc_div.sv
// Pipelined restoring divider, one quotient bit per stage, 32-bit dividend by 16-bit divisor.
// Side data rides along each stage. Depends on alc_pkg.
module alc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [31:0]       i_num,
    input  logic [15:0]       i_den,
    input  alc_pkg::t_div_side i_side,
    output logic              o_valid,
    output logic [31:0]       o_quo,
    output alc_pkg::t_div_side o_side
);
    import alc_pkg::*;

    logic        w_vld  [0:DIV_STEPS];
    logic [15:0] w_rem  [0:DIV_STEPS];
    logic [31:0] w_nq   [0:DIV_STEPS];
    logic [15:0] w_den  [0:DIV_STEPS];
    t_div_side   w_side [0:DIV_STEPS];

    assign w_vld[0]  = i_valid;
    assign w_rem[0]  = '0;
    assign w_nq[0]   = i_num;
    assign w_den[0]  = i_den;
    assign w_side[0] = i_side;

    // The dividend shifts out of the top of w_nq while quotient bits shift in below.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic        r_vld;
        logic [15:0] r_rem;
        logic [31:0] r_nq;
        logic [15:0] r_den;
        t_div_side   r_side;
        logic [16:0] w_trial;
        logic [16:0] w_diff;
        logic        w_ge;

        assign w_trial = {w_rem[k], w_nq[k][31]};
        assign w_diff  = w_trial - {1'b0, w_den[k]};
        assign w_ge    = (w_trial >= {1'b0, w_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_adv) begin
                r_vld <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem  <= w_ge ? w_diff[15:0] : w_trial[15:0];
                r_nq   <= {w_nq[k][30:0], w_ge};
                r_den  <= w_den[k];
                r_side <= w_side[k];
            end
        end

        assign w_vld[k+1]  = r_vld;
        assign w_rem[k+1]  = r_rem;
        assign w_nq[k+1]   = r_nq;
        assign w_den[k+1]  = r_den;
        assign w_side[k+1] = r_side;
    end

    assign o_valid = w_vld[DIV_STEPS];
    assign o_quo   = w_nq[DIV_STEPS];
    assign o_side  = w_side[DIV_STEPS];

endmodule

// File: hdl/alc_back.sv
// Back end: scaled counts, linear term, ratio divider, correction and fixed-point lux split,
// ending in the result register. Depends on alc_pkg and alc_div.
module alc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    input  alc_pkg::t_item  i_item,
    output logic            o_item_pop,
    output logic            o_res_valid,
    output alc_pkg::t_result o_result,
    input  logic            i_res_pop
);
    import alc_pkg::*;

    logic w_adv;

    // Stage 1: scaled counts.
    logic        r_s1_vld;
    t_tag        r_s1_tag;
    logic [15:0] r_s1_c0, r_s1_c1;
    logic [24:0] r_s1_d0, r_s1_d1;
    // Stage 2: products of the linear term.
    logic        r_s2_vld;
    t_tag        r_s2_tag;
    logic [15:0] r_s2_c0, r_s2_c1;
    logic [39:0] r_s2_pa;
    logic [37:0] r_s2_pb;
    // Stage 3: linear term.
    logic        r_s3_vld;
    t_div_side   r_s3_side;
    logic [15:0] r_s3_c0, r_s3_c1;
    // Divider output.
    logic        w_dv_vld;
    logic [31:0] w_dv_quo;
    t_div_side   w_dv_side;
    // P1: offset ratio.
    logic        r_p1_vld;
    t_div_side   r_p1_side;
    logic [32:0] r_p1_t;
    // P2: slope partial products.
    logic        r_p2_vld;
    t_div_side   r_p2_side;
    logic [44:0] r_p2_ph;
    logic [43:0] r_p2_pl;
    // P3: slope term.
    logic        r_p3_vld;
    t_div_side   r_p3_side;
    logic [36:0] r_p3_m;
    logic [60:0] w_p3_sum;
    // P4: magnitudes and sign decision.
    logic        r_p4_vld;
    logic [2:0]  r_p4_code;
    logic        r_p4_fz;
    logic [39:0] r_p4_lmag;
    logic [33:0] r_p4_cmag;
    logic [36:0] w_cmag_full;
    logic        w_cneg;
    logic [40:0] w_labs;
    logic [2:0]  w_code4;
    logic        w_fz4;
    // P5: partial products of lux.
    logic        r_p5_vld;
    logic [2:0]  r_p5_code;
    logic        r_p5_fz;
    logic [36:0] r_p5_p11, r_p5_p10, r_p5_p01, r_p5_p00;
    // P6: pair sums.
    logic        r_p6_vld;
    logic [2:0]  r_p6_code;
    logic        r_p6_fz;
    logic [73:0] r_p6_sa;
    logic [54:0] r_p6_sb;
    // P7: full lux in Q40.
    logic        r_p7_vld;
    logic [2:0]  r_p7_code;
    logic        r_p7_fz;
    logic        r_p7_sat;
    logic [17:0] r_p7_ip;
    logic [39:0] r_p7_fr;
    logic [73:0] w_prod;
    // P8: fraction times one million, in halves.
    logic        r_p8_vld;
    logic [2:0]  r_p8_code;
    logic        r_p8_fz;
    logic        r_p8_sat;
    logic [17:0] r_p8_ip;
    logic [39:0] r_p8_f1, r_p8_f0;
    logic [60:0] w_micro_sum;
    // Result register.
    logic        r_out_valid;
    t_result     r_out_res;
    t_result     n_out_res;

    assign w_adv       = !r_out_valid || i_res_pop;
    assign o_item_pop  = w_adv && i_item_valid;
    assign o_res_valid = r_out_valid;
    assign o_result    = r_out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_p1_vld    <= 1'b0;
            r_p2_vld    <= 1'b0;
            r_p3_vld    <= 1'b0;
            r_p4_vld    <= 1'b0;
            r_p5_vld    <= 1'b0;
            r_p6_vld    <= 1'b0;
            r_p7_vld    <= 1'b0;
            r_p8_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld    <= i_item_valid;
            r_s2_vld    <= r_s1_vld;
            r_s3_vld    <= r_s2_vld;
            r_p1_vld    <= w_dv_vld;
            r_p2_vld    <= r_p1_vld;
            r_p3_vld    <= r_p2_vld;
            r_p4_vld    <= r_p3_vld;
            r_p5_vld    <= r_p4_vld;
            r_p6_vld    <= r_p5_vld;
            r_p7_vld    <= r_p6_vld;
            r_p8_vld    <= r_p7_vld;
            r_out_valid <= r_p8_vld;
        end
    end

    // Front of the pipe, ahead of the divider.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_tag <= i_item.tag;
            r_s1_c0  <= i_item.ch0;
            r_s1_c1  <= i_item.ch1;
            r_s1_d0  <= 25'(i_item.ch0) * 25'(i_item.scale);
            r_s1_d1  <= 25'(i_item.ch1) * 25'(i_item.scale);

            r_s2_tag <= r_s1_tag;
            r_s2_c0  <= r_s1_c0;
            r_s2_c1  <= r_s1_c1;
            r_s2_pa  <= 40'(r_s1_d0) * 40'(COEF_A);
            r_s2_pb  <= 38'(r_s1_d1) * 38'(coef_b(r_s1_tag.region));

            r_s3_side.tag <= r_s2_tag;
            r_s3_side.lin <= {1'b0, r_s2_pa} - {3'b000, r_s2_pb};
            r_s3_c0       <= r_s2_c0;
            r_s3_c1       <= r_s2_c1;
        end
    end

    // The scale cancels in the ratio, so the raw counts are divided.
    alc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_s3_vld),
        .i_num   ({r_s3_c1, 16'h0000}),
        .i_den   (r_s3_c0),
        .i_side  (r_s3_side),
        .o_valid (w_dv_vld),
        .o_quo   (w_dv_quo),
        .o_side  (w_dv_side)
    );

    assign w_p3_sum = (61'(r_p2_ph) << 16) + 61'(r_p2_pl);

    always_comb begin
        if (coef_k_neg(r_p3_side.tag.region)) begin
            if (r_p3_m > CORR_ONE) begin
                w_cmag_full = r_p3_m - CORR_ONE;
                w_cneg      = 1'b1;
            end else begin
                w_cmag_full = CORR_ONE - r_p3_m;
                w_cneg      = 1'b0;
            end
        end else begin
            w_cmag_full = r_p3_m + CORR_ONE;
            w_cneg      = 1'b0;
        end
        w_labs = r_p3_side.lin[40] ? (~r_p3_side.lin + 41'd1) : r_p3_side.lin;
        if (r_p3_side.tag.code != CODE_OK) begin
            w_code4 = r_p3_side.tag.code;
            w_fz4   = 1'b1;
        end else if ((w_labs == '0) || (w_cmag_full == '0)) begin
            w_code4 = CODE_OK;
            w_fz4   = 1'b1;
        end else if (r_p3_side.lin[40] != w_cneg) begin
            w_code4 = CODE_NEG;
            w_fz4   = 1'b1;
        end else begin
            w_code4 = CODE_OK;
            w_fz4   = 1'b0;
        end
    end

    assign w_prod      = r_p6_sa + 74'(r_p6_sb);
    assign w_micro_sum = (61'(r_p8_f1) << 20) + 61'(r_p8_f0);

    // Back of the pipe, after the divider.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1_side <= w_dv_side;
            r_p1_t    <= 33'(w_dv_quo) + 33'(coef_off(w_dv_side.tag.region));

            r_p2_side <= r_p1_side;
            r_p2_ph   <= 45'(r_p1_t[32:16]) * 45'(coef_k(r_p1_side.tag.region));
            r_p2_pl   <= 44'(r_p1_t[15:0]) * 44'(coef_k(r_p1_side.tag.region));

            r_p3_side <= r_p2_side;
            r_p3_m    <= w_p3_sum[60:24];

            // The correction magnitude stays below 2^34 for any ratio.
            r_p4_code <= w_code4;
            r_p4_fz   <= w_fz4;
            r_p4_lmag <= w_labs[39:0];
            r_p4_cmag <= w_cmag_full[33:0];

            r_p5_code <= r_p4_code;
            r_p5_fz   <= r_p4_fz;
            r_p5_p11  <= 37'(r_p4_lmag[39:20]) * 37'(r_p4_cmag[33:17]);
            r_p5_p10  <= 37'(r_p4_lmag[39:20]) * 37'(r_p4_cmag[16:0]);
            r_p5_p01  <= 37'(r_p4_lmag[19:0]) * 37'(r_p4_cmag[33:17]);
            r_p5_p00  <= 37'(r_p4_lmag[19:0]) * 37'(r_p4_cmag[16:0]);

            r_p6_code <= r_p5_code;
            r_p6_fz   <= r_p5_fz;
            r_p6_sa   <= (74'(r_p5_p11) << 37) + (74'(r_p5_p10) << 20);
            r_p6_sb   <= (55'(r_p5_p01) << 17) + 55'(r_p5_p00);

            r_p7_code <= r_p6_code;
            r_p7_fz   <= r_p6_fz;
            r_p7_sat  <= (w_prod[73:58] != '0);
            r_p7_ip   <= w_prod[57:40];
            r_p7_fr   <= w_prod[39:0];

            r_p8_code <= r_p7_code;
            r_p8_fz   <= r_p7_fz;
            r_p8_sat  <= r_p7_sat;
            r_p8_ip   <= r_p7_ip;
            r_p8_f1   <= 40'(r_p7_fr[39:20]) * 40'(MICRO_SCALE);
            r_p8_f0   <= 40'(r_p7_fr[19:0]) * 40'(MICRO_SCALE);

            r_out_res <= n_out_res;
        end
    end

    always_comb begin
        n_out_res.result_code = r_p8_code;
        if (r_p8_fz) begin
            n_out_res.lux_integer = '0;
            n_out_res.lux_micro   = '0;
        end else if (r_p8_sat) begin
            n_out_res.lux_integer = LUX_INT_MAX;
            n_out_res.lux_micro   = LUX_MICRO_MAX;
        end else begin
            n_out_res.lux_integer = r_p8_ip;
            n_out_res.lux_micro   = w_micro_sum[59:40];
        end
    end

endmodule

// File: hdl/alc_checker.sv
// Port-level checks for the ambient light lux converter, attached by a bind statement.
// Depends on alc_pkg and the top level ambient_light_lux_converter.
module alc_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input alc_pkg::t_result o_result
);
    import alc_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input side full after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("waiting result word changed or vanished");

    // Every error code comes with both lux fields cleared.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_result.result_code != CODE_OK) |->
        (o_result.lux_integer == '0) && (o_result.lux_micro == '0))
        else $error("error result carries a lux value");

    a_micro_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.lux_micro <= LUX_MICRO_MAX))
        else $error("millionths field out of range");

endmodule

bind ambient_light_lux_converter alc_checker u_alc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

// File: bench/tb_ambient_light_lux_converter.sv
// Self-checking bench for the ambient light lux converter: directed table, then random samples,
// checked word by word against a local lux predictor. Depends on alc_pkg and the block's RTL.
module tb_ambient_light_lux_converter;
    import alc_pkg::*;

    localparam int DRAIN_CYCLES = 80;

    logic    i_clk;
    logic    i_rst_n;
    logic    push;
    logic    full;
    t_sample i_sample;
    logic    empty;
    logic    pop;
    t_result o_result;
    logic    i_cfg_we;
    logic [8:0] i_cfg_wdata;

    t_result pending_lux[$];
    logic [8:0] scale_now;
    bit      quiet;
    int      errors;
    int      words_in;
    int      words_out;
    int      scale_writes;

    ambient_light_lux_converter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_sample    (i_sample),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_result lux_of(input t_sample smp, input logic [8:0] scale);
        t_result     res;
        logic [63:0] s, d0, d1, ratio, t, b, off, kmag, m, lin_mag, corr_mag, fr;
        logic [127:0] prod;
        logic [1:0]  region;
        longint      lin, corr;
        bit          kneg;
        res = '0;
        s = (scale == 0) ? 64'd1 : {55'd0, scale};
        if (!smp.status_byte[7]) begin
            res.result_code = CODE_BUSY;
            return res;
        end
        if (smp.ch0_count == 16'hFFFF) begin
            res.result_code = CODE_SAT;
            return res;
        end
        if (smp.ch0_count == 16'd0) begin
            res.result_code = CODE_ZERO;
            return res;
        end
        d0 = smp.ch0_count * s;
        d1 = smp.ch1_count * s;
        if (d1 * 100 < d0 * 29)      region = REGION_LOW;
        else if (d1 * 100 < d0 * 35) region = REGION_MID;
        else if (d1 * 100 < d0 * 40) region = REGION_HIGH;
        else                         region = REGION_TOP;
        case (region)
            REGION_LOW:  begin b = 424;  off = 19005; kmag = 0;         kneg = 0; end
            REGION_MID:  begin b = 424;  off = 19005; kmag = 97861501;  kneg = 0; end
            REGION_HIGH: begin b = 4244; off = 18677; kmag = 167772160; kneg = 1; end
            default:     begin b = 4244; off = 19267; kmag = 23773315;  kneg = 1; end
        endcase
        ratio = (d1 << 16) / d0;
        t = ratio + off;
        m = (t * kmag) >> 24;
        lin = longint'(27615 * d0) - longint'(b * d1);
        corr = kneg ? 65536 - longint'(m) : 65536 + longint'(m);
        lin_mag = (lin < 0) ? -lin : lin;
        corr_mag = (corr < 0) ? -corr : corr;
        res.result_code = CODE_OK;
        if (lin_mag == 0 || corr_mag == 0) return res;
        if ((lin < 0) != (corr < 0)) begin
            res.result_code = CODE_NEG;
            return res;
        end
        prod = {64'd0, lin_mag} * {64'd0, corr_mag};
        if ((prod >> 40) > LUX_INT_MAX) begin
            res.lux_integer = LUX_INT_MAX;
            res.lux_micro = LUX_MICRO_MAX;
            return res;
        end
        fr = {24'd0, prod[39:0]};
        res.lux_integer = prod[57:40];
        res.lux_micro = 20'((fr * 64'd1000000) >> 40);
        return res;
    endfunction

    function automatic bit idle_roll();
        return !quiet && ($urandom_range(99) < 21);
    endfunction

    // Holds push high until the word is taken at an edge where full is low.
    task automatic send_word(input t_sample smp, input bit typed, input t_result want);
        while (idle_roll()) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_sample <= smp;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pending_lux.push_back(typed ? want : lux_of(smp, scale_now));
        words_in++;
    endtask

    task automatic write_scale(input logic [8:0] value);
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_lux.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        scale_now = value;
        scale_writes++;
    endtask

    function automatic t_sample rand_sample();
        t_sample smp;
        int      sel;
        smp.status_byte = 8'($urandom);
        if ($urandom_range(99) < 88) smp.status_byte[7] = 1'b1;
        sel = $urandom_range(99);
        if (sel < 3)       smp.ch0_count = 16'hFFFF;
        else if (sel < 6)  smp.ch0_count = 16'd0;
        else if (sel < 40) smp.ch0_count = 16'($urandom_range(1, 300));
        else               smp.ch0_count = 16'($urandom);
        sel = $urandom_range(99);
        // Most ch1 values sit near the region boundaries so every region gets hit.
        if (sel < 60)
            smp.ch1_count = 16'((smp.ch0_count * $urandom_range(20, 50)) / 100
                                + $urandom_range(0, 2));
        else if (sel < 80)
            smp.ch1_count = 16'((smp.ch0_count * $urandom_range(0, 800)) / 100);
        else
            smp.ch1_count = 16'($urandom);
        return smp;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                words_out++;
                if (pending_lux.size() == 0) begin
                    $display("%0t: result word with nothing expected: %p", $time, o_result);
                    errors++;
                end else begin
                    if (o_result.result_code !== pending_lux[0].result_code) begin
                        $display("%0t: result_code expected %0d actual %0d", $time,
                                 pending_lux[0].result_code, o_result.result_code);
                        errors++;
                    end
                    if (o_result.lux_integer !== pending_lux[0].lux_integer) begin
                        $display("%0t: lux_integer expected %0d actual %0d", $time,
                                 pending_lux[0].lux_integer, o_result.lux_integer);
                        errors++;
                    end
                    if (o_result.lux_micro !== pending_lux[0].lux_micro) begin
                        $display("%0t: lux_micro expected %0d actual %0d", $time,
                                 pending_lux[0].lux_micro, o_result.lux_micro);
                        errors++;
                    end
                    void'(pending_lux.pop_front());
                end
            end
            pop <= !idle_roll();
        end
    end

    typedef struct {
        t_sample smp;
        bit      typed;
        t_result want;
    } t_row;

    t_row directed[$];

    task automatic add_row(input logic [7:0] st, input logic [15:0] c0, input logic [15:0] c1,
                           input bit typed, input logic [2:0] code);
        t_row row;
        row.smp = '{st, c0, c1};
        row.typed = typed;
        row.want = '{code, 18'd0, 20'd0};
        directed.push_back(row);
    endtask

    initial begin
        push = 1'b0;
        i_sample = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n = 1'b0;
        quiet = 0;
        errors = 0;
        words_in = 0;
        words_out = 0;
        scale_writes = 0;
        scale_now = SCALE_RESET;

        add_row(8'h00, 16'd100, 16'd10, 1, CODE_BUSY);
        add_row(8'h7F, 16'hFFFE, 16'hFFFF, 1, CODE_BUSY);
        add_row(8'h80, 16'hFFFF, 16'd0, 1, CODE_SAT);
        add_row(8'hFF, 16'hFFFF, 16'hFFFF, 1, CODE_SAT);
        add_row(8'h80, 16'd0, 16'd500, 1, CODE_ZERO);
        add_row(8'hFF, 16'd0, 16'd0, 1, CODE_ZERO);
        // Linear term exactly zero gives an ok code with zero lux.
        add_row(8'h80, 16'd4244, 16'd27615, 1, CODE_OK);
        add_row(8'h80, 16'd1, 16'd0, 0, CODE_OK);
        add_row(8'h80, 16'hFFFE, 16'd0, 0, CODE_OK);
        add_row(8'h80, 16'hFFFE, 16'hFFFE, 0, CODE_OK);
        add_row(8'h80, 16'd1, 16'hFFFF, 0, CODE_OK);
        add_row(8'h80, 16'd100, 16'd28, 0, CODE_OK);
        add_row(8'h80, 16'd100, 16'd29, 0, CODE_OK);
        add_row(8'h80, 16'd100, 16'd34, 0, CODE_OK);
        add_row(8'h80, 16'd100, 16'd35, 0, CODE_OK);
        add_row(8'h80, 16'd100, 16'd36, 0, CODE_OK);
        add_row(8'h80, 16'd100, 16'd39, 0, CODE_OK);
        add_row(8'h80, 16'd100, 16'd40, 0, CODE_OK);
        add_row(8'h80, 16'd100, 16'd300, 0, CODE_OK);
        add_row(8'hC3, 16'h5555, 16'hAAAA, 0, CODE_OK);
        add_row(8'hBC, 16'hAAAA, 16'h5555, 0, CODE_OK);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_word(directed[i].smp, directed[i].typed, directed[i].want);

        // Scale settings: extremes, zero treated as one, above-nominal and random values.
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: write_scale(9'd1);
                1: write_scale(9'd0);
                2: write_scale(9'd511);
                3: write_scale(9'd257);
                4: write_scale(9'($urandom_range(2, 255)));
                5: write_scale(9'($urandom_range(0, 511)));
                default: write_scale(9'd256);
            endcase
            for (int n = 0; n < 160; n++) begin
                quiet = (phase == 3) && (n >= 20) && (n < 140);
                send_word(rand_sample(), 0, '0);
            end
            quiet = 0;
        end

        push <= 1'b0;
        @(posedge i_clk);
        while (pending_lux.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d sample words and %0d result words over %0d scale writes,",
                 words_in, words_out, scale_writes);
        $display("with busy, saturated, zero, negative and all four ratio regions exercised.");
        if (errors == 0) begin
            $display("ambient_light_lux_converter regression: pass");
        end else begin
            $display("ambient_light_lux_converter regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d result words outstanding.", pending_lux.size());
        $display("ambient_light_lux_converter regression: fail");
        $finish;
    end

endmodule
